[hdl/ldbh_pkg.sv]
// ============================================================================
// ldbh_pkg: shared types and constants of the loop detector
// Field widths, reset values, request and register codes and the FIFO
// command struct used by the detector modules and channel interfaces.
// ============================================================================
`default_nettype none

package ldbh_pkg;

   // Field and register widths.
   localparam int unsigned PERIOD_W    = 16;
   localparam int unsigned ACC_W       = 24;
   localparam int unsigned ACC_SHIFT   = 8;
   localparam int unsigned CSR_INDEX_W = 8;

   typedef logic [PERIOD_W-1:0]    period_type;
   typedef logic [ACC_W-1:0]       acc_type;
   typedef logic [CSR_INDEX_W-1:0] csr_addr_type;

   // Reset values of the baseline tracker and the margin registers.
   localparam period_type BASE_RESET  = 16'd17000;
   localparam acc_type    ACC_RESET   = 24'd4352000;
   localparam period_type ENTER_RESET = 16'd50;
   localparam period_type EXIT_RESET  = 16'd30;

   // Request codes carried in the req_type field.
   typedef enum logic {
      REQ_MEASURE = 1'b0,
      REQ_READ    = 1'b1
   } req_code_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENTER_MARGIN = 8'd0,
      CSR_EXIT_MARGIN  = 8'd1
   } csr_index_type;

   // Per-cycle command from the top level to the FIFO store.
   typedef struct packed {
      logic       push;
      logic       pop;
      period_type data;
   } fifo_cmd_type;

endpackage

`default_nettype wire

[hdl/ldbh_if.sv]
// ============================================================================
// Channel interfaces of the loop detector
// Request, response and register-write channels, each with valid, ready
// and its payload.
// ============================================================================
`default_nettype none

interface ldbh_req_if;
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   ldbh_pkg::period_type period;

   modport source (output valid, output req_type, output period, input ready);
   modport sink   (input valid, input req_type, input period, output ready);
endinterface

interface ldbh_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 vehicle_present;
   ldbh_pkg::period_type baseline;
   logic                 read_valid;
   ldbh_pkg::period_type read_data;

   modport source (output valid, output vehicle_present, output baseline,
                   output read_valid, output read_data, input ready);
   modport sink   (input valid, input vehicle_present, input baseline,
                   input read_valid, input read_data, output ready);
endinterface

interface ldbh_csr_if;
   logic                   valid;
   logic                   ready;
   ldbh_pkg::csr_addr_type index;
   ldbh_pkg::period_type   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/loop_detector_baseline_hysteresis_top.sv]
// ============================================================================
// loop_detector_baseline_hysteresis_top: inductive loop vehicle detector
// Tracks a baseline loop period with a vehicle flag under hysteresis and
// keeps the raw periods in a ring store that can be read back.
// ============================================================================
//
//   Channel  Direction  Contents
//   req_ch   in         req_type, period
//   rsp_ch   out        vehicle_present, baseline, read_valid, read_data
//   csr_ch   in         index, data (0 = enter_margin, 1 = exit_margin)
//
// One item per cycle while rsp_ch takes each response, which is valid in the
// cycle after acceptance. The limit is the baseline loop: accumulator update
// and threshold compare in the same cycle. Read data comes from the store's
// registered read port into the response. Synchronous reset; the store needs
// no clearing pass, so items are taken from the first cycle after reset.
// req_ch stalls only while a response is held by rsp_ch; csr_ch is always ready.
// ============================================================================
`default_nettype none

module loop_detector_baseline_hysteresis_top #(
   parameter int unsigned FIFO_DEPTH = 1024
) (
   input wire   clock,
   input wire   reset,
   ldbh_req_if.sink   req_ch,
   ldbh_rsp_if.source rsp_ch,
   ldbh_csr_if.sink   csr_ch
);
   import ldbh_pkg::*;

   logic         req_accept;
   logic         is_measure;
   fifo_cmd_type fifo_cmd;
   logic         fifo_not_empty;
   period_type   fifo_q;
   period_type   enter_margin;
   period_type   exit_margin;

   logic rsp_valid_ff, rsp_valid_in;
   logic rd_valid_ff, rd_valid_in;

   // Input handshake: take an item whenever the response slot frees up.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign is_measure   = (req_ch.req_type == REQ_MEASURE);

   assign csr_ch.ready = 1'b1;

   ldbh_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (csr_ch.valid && csr_ch.ready),
      .wr_index     (csr_ch.index),
      .wr_data      (csr_ch.data),
      .enter_margin (enter_margin),
      .exit_margin  (exit_margin)
   );

   ldbh_track u_track (
      .clock           (clock),
      .reset           (reset),
      .measure         (req_accept && is_measure),
      .period          (req_ch.period),
      .enter_margin    (enter_margin),
      .exit_margin     (exit_margin),
      .vehicle_present (rsp_ch.vehicle_present),
      .baseline        (rsp_ch.baseline)
   );

   // Store command: push every measurement, pop only a non-empty store.
   always_comb begin
      fifo_cmd.push = req_accept && is_measure;
      fifo_cmd.pop  = req_accept && !is_measure && fifo_not_empty;
      fifo_cmd.data = req_ch.period;
   end

   ldbh_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .cmd       (fifo_cmd),
      .not_empty (fifo_not_empty),
      .rd_data   (fifo_q)
   );

   // Response register: filled on acceptance, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rd_valid_in  = rd_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rd_valid_in  = fifo_cmd.pop;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_valid = rd_valid_ff;
   assign rsp_ch.read_data  = rd_valid_ff ? fifo_q : '0;

`ifndef SYNTHESIS
   // A measurement never reports read data.
   a_measure_no_read: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_measure) |=> (rsp_ch.valid && !rsp_ch.read_valid))
      else $error("measurement response carries read_valid");

   // A read leaves the baseline and the vehicle flag untouched.
   a_read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_measure) |=>
         (rsp_ch.baseline == $past(rsp_ch.baseline)) &&
         (rsp_ch.vehicle_present == $past(rsp_ch.vehicle_present)))
      else $error("read changed baseline or vehicle flag");

   // A read of an empty store returns not-valid.
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_measure && !fifo_not_empty) |=> !rsp_ch.read_valid)
      else $error("read of empty store reported valid");

   // The store is never pushed and popped in the same cycle.
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(fifo_cmd.push && fifo_cmd.pop))
      else $error("store pushed and popped together");
`endif

endmodule

`default_nettype wire

[hdl/ldbh_csr.sv]
// ============================================================================
// ldbh_csr: margin registers
// Holds the enter and exit margins and takes a write in every cycle.
// ============================================================================
`default_nettype none

module ldbh_csr (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         wr_en,
   input  wire ldbh_pkg::csr_addr_type wr_index,
   input  wire ldbh_pkg::period_type   wr_data,
   output ldbh_pkg::period_type        enter_margin,
   output ldbh_pkg::period_type        exit_margin
);
   import ldbh_pkg::*;

   period_type enter_ff, enter_in;
   period_type exit_ff, exit_in;

   // Decode the register index; unknown indexes leave both registers alone.
   always_comb begin
      enter_in = enter_ff;
      exit_in  = exit_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_ENTER_MARGIN: enter_in = wr_data;
            CSR_EXIT_MARGIN:  exit_in  = wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_ff <= ENTER_RESET;
         exit_ff  <= EXIT_RESET;
      end else begin
         enter_ff <= enter_in;
         exit_ff  <= exit_in;
      end
   end

   assign enter_margin = enter_ff;
   assign exit_margin  = exit_ff;

endmodule

`default_nettype wire

[hdl/ldbh_track.sv]
// ============================================================================
// ldbh_track: baseline average and vehicle flag
// Updates the running baseline while no vehicle is present and applies the
// enter and exit thresholds to each new measurement.
// ============================================================================
`default_nettype none

module ldbh_track (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       measure,
   input  wire ldbh_pkg::period_type period,
   input  wire ldbh_pkg::period_type enter_margin,
   input  wire ldbh_pkg::period_type exit_margin,
   output logic                      vehicle_present,
   output ldbh_pkg::period_type      baseline
);
   import ldbh_pkg::*;

   acc_type    acc_ff, acc_in;
   period_type base_ff, base_in;
   logic       flag_ff, flag_in;

   acc_type    acc_upd;
   period_type base_cur;
   logic [PERIOD_W:0] enter_sum;
   logic [PERIOD_W:0] exit_sum;
   logic [PERIOD_W:0] base_ext;

   // The accumulator leaks 1/256 of itself and adds the new period.
   assign acc_upd = acc_ff - {{ACC_SHIFT{1'b0}}, acc_ff[ACC_W-1:ACC_SHIFT]}
                    + {{(ACC_W-PERIOD_W){1'b0}}, period};

   // The thresholds are taken against the baseline after this update.
   // period < base - margin is tested as period + margin < base, which
   // never wraps and so keeps the signed meaning.
   assign base_cur  = flag_ff ? base_ff : acc_upd[ACC_W-1:ACC_SHIFT];
   assign base_ext  = {1'b0, base_cur};
   assign enter_sum = {1'b0, period} + {1'b0, enter_margin};
   assign exit_sum  = {1'b0, period} + {1'b0, exit_margin};

   always_comb begin
      acc_in  = acc_ff;
      base_in = base_ff;
      flag_in = flag_ff;
      if (measure) begin
         if (!flag_ff) begin
            acc_in  = acc_upd;
            base_in = base_cur;
         end
         if (enter_sum < base_ext) begin
            flag_in = 1'b1;
         end else if (exit_sum > base_ext) begin
            flag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= ACC_RESET;
         base_ff <= BASE_RESET;
         flag_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         base_ff <= base_in;
         flag_ff <= flag_in;
      end
   end

   assign vehicle_present = flag_ff;
   assign baseline        = base_ff;

endmodule

`default_nettype wire

[hdl/ldbh_fifo.sv]
// ============================================================================
// ldbh_fifo: ring store of raw periods
// A synchronous memory with one write and one registered read port, and the
// head and tail pointers that wrap at the store depth.
// ============================================================================
`default_nettype none

module ldbh_fifo #(
   parameter int unsigned FIFO_DEPTH = 1024
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire ldbh_pkg::fifo_cmd_type cmd,
   output logic                        not_empty,
   output ldbh_pkg::period_type        rd_data
);
   import ldbh_pkg::*;

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);

   period_type mem [FIFO_DEPTH];
   period_type q_ff;

   logic [PTR_W-1:0] head_ff, head_in, head_next;
   logic [PTR_W-1:0] tail_ff, tail_in, tail_next;

   // Slot after each pointer, wrapping at the last entry.
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;

   assign not_empty = (head_ff != tail_ff);

   // A push advances the head with no full check; a pop advances the tail.
   always_comb begin
      head_in = cmd.push ? head_next : head_ff;
      tail_in = cmd.pop  ? tail_next : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Memory ports. Push and pop never fall in the same cycle, so an entry
   // is never read at the edge that writes it.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[head_next] <= cmd.data;
      end
      if (cmd.pop) begin
         q_ff <= mem[tail_next];
      end
   end

   assign rd_data = q_ff;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the loop vehicle detector
// Sends period measurements and ring read requests over the request channel
// and register writes over the register channel. Every accepted item runs
// through a predictor of the baseline tracker, the hysteresis flag and the
// ring store. Each response is compared field by field, in order, with the
// oldest predicted report. Both sides idle and stall at random.
// ============================================================================
`default_nettype none

module tb_top;
   import ldbh_pkg::*;

   localparam int unsigned RING_DEPTH = 1024;
   localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
   localparam int unsigned MAX_LOGGED = 10;

   // One report as the detector gives it back for an item.
   typedef struct packed {
      logic       vehicle_present;
      period_type baseline;
      logic       read_valid;
      period_type read_data;
   } loop_report_type;

   logic clock;
   logic reset;

   ldbh_req_if req_bus ();
   ldbh_rsp_if rsp_bus ();
   ldbh_csr_if csr_bus ();

   loop_detector_baseline_hysteresis_top #(
      .FIFO_DEPTH (RING_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Mirror of the detector state and its margin registers.
   period_type       enter_thr;
   period_type       exit_thr;
   acc_type          base_acc;
   period_type       base_avg;
   logic             vehicle_seen;
   period_type       period_ring [RING_DEPTH];
   logic [PTR_W-1:0] ring_head;
   logic [PTR_W-1:0] ring_tail;

   loop_report_type pending_reports [$];
   int              error_count;
   bit              send_gaps;
   bit              take_gaps;
   int              hold_request;

   // Clock with a 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #2_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // Put the mirror into its state after reset.
   task automatic reset_mirror();
      enter_thr    = ENTER_RESET;
      exit_thr     = EXIT_RESET;
      base_acc     = ACC_RESET;
      base_avg     = BASE_RESET;
      vehicle_seen = 1'b0;
      ring_head    = '0;
      ring_tail    = '0;
   endtask

   // Apply one item to the mirror and return the report it causes.
   function automatic loop_report_type detector_step(input req_code_type code,
                                                     input period_type p);
      loop_report_type rep;
      logic [31:0]     acc_next;
      int              p_i;
      int              base_i;
      rep = '0;
      if (code == REQ_MEASURE) begin
         ring_head = ring_head + 1'b1;
         period_ring[ring_head] = p;
         // The baseline only follows the loop while no vehicle is over it.
         if (!vehicle_seen) begin
            acc_next = 32'(base_acc) - 32'(base_acc >> ACC_SHIFT) + 32'(p);
            base_acc = acc_next[ACC_W-1:0];
            base_avg = base_acc[ACC_W-1:ACC_SHIFT];
         end
         // Hysteresis against the updated baseline, compared as signed values.
         p_i    = p;
         base_i = base_avg;
         if (p_i < base_i - int'(enter_thr)) begin
            vehicle_seen = 1'b1;
         end else if (p_i > base_i - int'(exit_thr)) begin
            vehicle_seen = 1'b0;
         end
      end else if (ring_tail != ring_head) begin
         ring_tail     = ring_tail + 1'b1;
         rep.read_valid = 1'b1;
         rep.read_data  = period_ring[ring_tail];
      end
      rep.vehicle_present = vehicle_seen;
      rep.baseline        = base_avg;
      return rep;
   endfunction

   // Pick a period, mostly around the baseline within reach of the margins.
   function automatic period_type pick_period();
      int v;
      int b;
      int span;
      b    = base_avg;
      span = ((enter_thr > exit_thr) ? int'(enter_thr) : int'(exit_thr)) + 120;
      case ($urandom_range(0, 19))
         0:       v = 0;
         1:       v = 65535;
         2, 3:    v = $urandom_range(65535);
         default: v = b + 60 - int'($urandom_range(span));
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return period_type'(v);
   endfunction

   // Send one item; valid stays high until a gap or a drain lowers it.
   task automatic send_item(input req_code_type code, input period_type p);
      bit taken;
      while (send_gaps && $urandom_range(0, 99) < 38) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= code;
      req_bus.period   <= p;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      pending_reports.push_back(detector_step(code, p));
   endtask

   // Stop sending and wait until every predicted report has come back.
   task automatic wait_reports_drained();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write one register; unknown indexes leave the margins alone.
   task automatic write_reg(input csr_addr_type idx, input period_type value);
      bit taken;
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do begin
         @(negedge clock);
         taken = csr_bus.ready;
         @(posedge clock);
      end while (!taken);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ENTER_MARGIN) begin
         enter_thr = value;
      end else if (idx == CSR_EXIT_MARGIN) begin
         exit_thr = value;
      end
   endtask

   // Change both margins once the detector is idle.
   task automatic set_margins(input period_type enter_value, input period_type exit_value);
      wait_reports_drained();
      write_reg(CSR_ENTER_MARGIN, enter_value);
      write_reg(CSR_EXIT_MARGIN, exit_value);
   endtask

   // Write to an index that holds no register.
   task automatic write_unused_index();
      wait_reports_drained();
      write_reg(csr_addr_type'($urandom_range(255, 2)), period_type'($urandom));
   endtask

   // A run of random measurements and reads.
   task automatic random_items(input int count, input int read_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < read_pct) begin
            send_item(REQ_READ, period_type'($urandom));
         end else begin
            send_item(REQ_MEASURE, pick_period());
         end
      end
   endtask

   // Empty ring, extreme periods, both hysteresis edges and reading back.
   task automatic test_directed();
      send_item(REQ_READ, 16'hFFFF);
      send_item(REQ_MEASURE, BASE_RESET);
      send_item(REQ_MEASURE, 16'd0);
      send_item(REQ_MEASURE, 16'd0);
      send_item(REQ_MEASURE, 16'hFFFF);
      send_item(REQ_MEASURE, base_avg - 16'd100);
      send_item(REQ_MEASURE, base_avg - 16'd40);
      send_item(REQ_MEASURE, base_avg - 16'd30);
      send_item(REQ_MEASURE, base_avg - 16'd29);
      send_item(REQ_MEASURE, base_avg - 16'd50);
      send_item(REQ_MEASURE, base_avg - 16'd51);
      repeat (12) send_item(REQ_READ, period_type'($urandom));
   endtask

   // Margins at their extremes, plus a write to an unknown index.
   task automatic test_margin_extremes();
      set_margins(16'd0, 16'd0);
      random_items(25, 20);
      set_margins(16'hFFFF, 16'hFFFF);
      repeat (6) send_item(REQ_MEASURE, 16'd0);
      random_items(20, 20);
      set_margins(16'd0, 16'hFFFF);
      random_items(20, 20);
      set_margins(16'hFFFF, 16'd0);
      random_items(20, 20);
      set_margins(ENTER_RESET, EXIT_RESET);
      write_unused_index();
      random_items(20, 20);
   endtask

   // Fill the ring until the head catches the tail and it looks empty.
   task automatic test_ring_overflow();
      while (ring_tail != ring_head) send_item(REQ_READ, '0);
      repeat (RING_DEPTH) send_item(REQ_MEASURE, pick_period());
      send_item(REQ_READ, 16'h5A5A);
      repeat (5) send_item(REQ_MEASURE, pick_period());
      repeat (7) send_item(REQ_READ, period_type'($urandom));
   endtask

   // Long receiver hold-off while items keep coming, then a full pause.
   task automatic test_backpressure();
      send_gaps    = 1'b0;
      hold_request = 90;
      random_items(60, 30);
      wait_reports_drained();
      send_gaps = 1'b1;
   endtask

   // Random phases with varied margins, read mixes and idling.
   task automatic test_random();
      period_type enter_value;
      period_type exit_value;
      int         read_pct;
      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(0, 5))
            0: begin
               enter_value = 16'd0;
               exit_value  = 16'd0;
            end
            1: begin
               enter_value = 16'hFFFF;
               exit_value  = 16'hFFFF;
            end
            2: begin
               enter_value = period_type'($urandom_range(400));
               exit_value  = period_type'($urandom_range(400));
            end
            3: begin
               enter_value = period_type'($urandom);
               exit_value  = period_type'($urandom);
            end
            4: begin
               enter_value = ENTER_RESET;
               exit_value  = EXIT_RESET;
            end
            default: begin
               enter_value = period_type'($urandom_range(60));
               exit_value  = period_type'($urandom_range(300, 60));
            end
         endcase
         set_margins(enter_value, exit_value);
         if ($urandom_range(0, 3) == 0) write_unused_index();
         case ($urandom_range(0, 2))
            0:       read_pct = 10;
            1:       read_pct = 30;
            default: read_pct = 60;
         endcase
         // One phase runs with no idling on either side.
         send_gaps = (ph != 4);
         take_gaps = (ph != 4);
         random_items(45, read_pct);
      end
      send_gaps = 1'b1;
      take_gaps = 1'b1;
   endtask

   // Response side: random ready, with a counted hold-off on request.
   initial begin : take_reports
      int hold;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= !(take_gaps && $urandom_range(0, 99) < 38);
      end
   end

   // Compare each accepted response with the oldest predicted report.
   always @(negedge clock) begin : check_reports
      loop_report_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            error_count++;
            if (error_count <= MAX_LOGGED) begin
               $display("tb_top: response with no item pending at %0t", $realtime);
            end
         end else begin
            want = pending_reports.pop_front();
            if (rsp_bus.vehicle_present !== want.vehicle_present ||
                rsp_bus.baseline !== want.baseline ||
                rsp_bus.read_valid !== want.read_valid ||
                rsp_bus.read_data !== want.read_data) begin
               error_count++;
               if (error_count <= MAX_LOGGED) begin
                  $display("tb_top: mismatch at %0t: expected vp=%0d base=%0d rv=%0d rd=%0d",
                           $realtime, want.vehicle_present, want.baseline,
                           want.read_valid, want.read_data);
                  $display("tb_top:   actual vp=%0d base=%0d rv=%0d rd=%0d",
                           rsp_bus.vehicle_present, rsp_bus.baseline,
                           rsp_bus.read_valid, rsp_bus.read_data);
               end
            end
         end
      end
   end

   // Test sequence.
   initial begin : run_tests
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_MEASURE;
      req_bus.period   <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= '0;
      csr_bus.data     <= '0;
      send_gaps    = 1'b1;
      take_gaps    = 1'b1;
      hold_request = 0;
      error_count  = 0;
      reset_mirror();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_margin_extremes();
      test_ring_overflow();
      test_backpressure();
      test_random();

      // Let the last reports arrive, with a bound.
      req_bus.valid <= 1'b0;
      for (int n = 0; n < 2000 && pending_reports.size() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
      error_count += pending_reports.size();
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

[loop_detector_baseline_hysteresis_top.f]
hdl/ldbh_pkg.sv
hdl/ldbh_if.sv
hdl/ldbh_csr.sv
hdl/ldbh_track.sv
hdl/ldbh_fifo.sv
hdl/loop_detector_baseline_hysteresis_top.sv
dv/tb_top.sv
